>>> rtl/core/assert_macros.svh
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sp_nh_pkg.sv
package sp_nh_pkg;
    localparam int MAX_NODE_COUNT = 32;
    localparam int WEIGHT_BITS    = 16;
    localparam int NODE_W         = $clog2(MAX_NODE_COUNT);
    localparam int CNT_W          = NODE_W + 1;
    localparam int COST_W         = 21;
    localparam int ADDR_W         = 2 * NODE_W;

    localparam logic       OP_LOAD    = 1'b0;
    localparam logic       OP_COMPUTE = 1'b1;

    localparam logic [1:0] RS_ROUTED  = 2'd0;
    localparam logic [1:0] RS_SELF    = 2'd1;
    localparam logic [1:0] RS_UNREACH = 2'd2;

    // One node record carried around the ring.
    typedef struct packed {
        logic              valid;
        logic              done;
        logic [COST_W-1:0] cost;
        logic [NODE_W-1:0] hop;
    } t_rec;

    // One adjacency matrix entry.
    typedef struct packed {
        logic                   absent;
        logic [WEIGHT_BITS-1:0] weight;
    } t_wt;

    // Node being settled in the current pass.
    typedef struct packed {
        logic              u_valid;
        logic [NODE_W-1:0] u;
        logic [COST_W-1:0] u_dist;
        logic [NODE_W-1:0] u_hop;
        logic [NODE_W-1:0] src;
    } t_relax_ctl;
endpackage

>>> rtl/core/sp_nh_cell.sv
module sp_nh_cell (
    input  logic            i_clk,
    input  logic            i_init,
    input  logic            i_seed,
    input  logic            i_shift,
    input  sp_nh_pkg::t_rec i_next,
    output sp_nh_pkg::t_rec o_rec
);
    sp_nh_pkg::t_rec r_rec;

    // Seed the source with distance zero, clear the rest; else advance the ring.
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_rec.valid <= i_seed;
            r_rec.done  <= 1'b0;
            r_rec.cost  <= '0;
            r_rec.hop   <= '0;
        end else if (i_shift) begin
            r_rec <= i_next;
        end
    end

    assign o_rec = r_rec;
endmodule

>>> rtl/core/sp_nh_relax.sv
module sp_nh_relax (
    input  sp_nh_pkg::t_rec                  i_rec,
    input  sp_nh_pkg::t_wt                   i_wt,
    input  sp_nh_pkg::t_relax_ctl            i_ctl,
    input  logic [sp_nh_pkg::NODE_W-1:0]     i_node,
    input  logic [sp_nh_pkg::CNT_W-1:0]      i_node_count,
    output sp_nh_pkg::t_rec                  o_rec,
    output logic                             o_cand
);
    logic                          active;
    logic                          is_u;
    logic [sp_nh_pkg::COST_W-1:0]  cand_dist;
    sp_nh_pkg::t_rec               rec;

    always_comb begin
        active    = {1'b0, i_node} < i_node_count;
        is_u      = i_ctl.u_valid && (i_node == i_ctl.u);
        cand_dist = i_ctl.u_dist + sp_nh_pkg::COST_W'(i_wt.weight);
        rec       = i_rec;
        if (is_u) begin
            rec.done = 1'b1;
        end else if (i_ctl.u_valid && active && !i_rec.done && !i_wt.absent &&
                     (!i_rec.valid || cand_dist < i_rec.cost)) begin
            rec.valid = 1'b1;
            rec.cost  = cand_dist;
            rec.hop   = (i_ctl.u == i_ctl.src) ? i_node : i_ctl.u_hop;
        end
        o_rec  = rec;
        o_cand = active && !rec.done && rec.valid;
    end
endmodule

>>> rtl/core/shortest_path_next_hop_table_top.sv
// Channel   Direction  Handshake                 Beat contents
// input     in         i_in_valid / o_in_ready   operation, row/col node, weight, absent
// result    out        o_out_valid / i_out_ready dest, first hop, cost, status, last
// config    in         i_cfg_valid / o_cfg_ready node_count (always ready)
//
// A load beat is one write of the 1024-entry weight memory.
// A compute beat runs search passes until a pass finds no unsettled reachable
// node: each pass prefetches from memory, then rotates the 32-cell ring once,
// relaxing against the settled node and picking the next minimum.
// Route beats then leave one per cycle while the output register drains.
// Synchronous active-low reset clears control; the weight memory is not cleared.
// A stalled result holds the ring; no new input is taken until the run ends.
`include "assert_macros.svh"

module shortest_path_next_hop_table_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic [4:0]                           i_row_node,
    input  logic [4:0]                           i_col_node,
    input  logic [15:0]                          i_edge_weight,
    input  logic                                 i_edge_absent,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [5:0]                           i_cfg_node_count,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [4:0]                           o_dest_node,
    output logic [4:0]                           o_first_hop,
    output logic [20:0]                          o_path_cost,
    output logic [1:0]                           o_route_status,
    output logic                                 o_last_entry
);
    localparam int NW = sp_nh_pkg::NODE_W;
    localparam int CW = sp_nh_pkg::CNT_W;
    localparam int DW = sp_nh_pkg::COST_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PREF   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0]     r_state;
    logic [5:0]     r_cfg;
    logic [CW-1:0]  r_n;
    logic [NW-1:0]  r_step;
    sp_nh_pkg::t_relax_ctl r_ctl;
    logic           r_found;
    logic [DW-1:0]  r_best_dist;
    logic [NW-1:0]  r_best_node;
    logic [NW-1:0]  r_best_hop;

    logic           n_found;
    logic [DW-1:0]  n_best_dist;
    logic [NW-1:0]  n_best_node;
    logic [NW-1:0]  n_best_hop;

    sp_nh_pkg::t_wt r_mem [sp_nh_pkg::MAX_NODE_COUNT * sp_nh_pkg::MAX_NODE_COUNT];
    sp_nh_pkg::t_wt r_wt;
    logic [sp_nh_pkg::ADDR_W-1:0] rd_addr;

    logic           r_out_valid;
    logic [NW-1:0]  r_dest;
    logic [NW-1:0]  r_hop;
    logic [DW-1:0]  r_cost;
    logic [1:0]     r_status;
    logic           r_last;

    sp_nh_pkg::t_rec w_rec [sp_nh_pkg::MAX_NODE_COUNT];
    sp_nh_pkg::t_rec head_upd;
    sp_nh_pkg::t_rec head_in;
    logic           head_cand;
    logic [CW-1:0]  n_eff;
    logic           in_acc;
    logic           compute_acc;
    logic           out_adv;
    logic           shift;

    // Clamp the node count: zero acts as one, large values saturate.
    always_comb begin
        if (r_cfg == '0) begin
            n_eff = CW'(1);
        end else if (r_cfg > 6'(sp_nh_pkg::MAX_NODE_COUNT)) begin
            n_eff = CW'(sp_nh_pkg::MAX_NODE_COUNT);
        end else begin
            n_eff = CW'(r_cfg);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign compute_acc = in_acc && (i_operation == sp_nh_pkg::OP_COMPUTE);
    assign out_adv     = !r_out_valid || i_out_ready;
    assign shift       = (r_state == ST_SEARCH) || ((r_state == ST_OUT) && out_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 6'(sp_nh_pkg::MAX_NODE_COUNT);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_node_count;
        end
    end

    // Weight memory: written by load beats, read one column ahead of the ring head.
    assign rd_addr = (r_state == ST_PREF) ? {r_ctl.u, NW'(0)} : {r_ctl.u, r_step + NW'(1)};

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_operation == sp_nh_pkg::OP_LOAD)) begin
            r_mem[{i_row_node, i_col_node}] <= {i_edge_absent,
                                                i_edge_weight[sp_nh_pkg::WEIGHT_BITS-1:0]};
        end
        r_wt <= r_mem[rd_addr];
    end

    // Ring of node cells; the processed head record re-enters at the tail.
    for (genvar g = 0; g < sp_nh_pkg::MAX_NODE_COUNT; g++) begin : g_cell
        sp_nh_pkg::t_rec nxt;
        if (g == sp_nh_pkg::MAX_NODE_COUNT - 1) begin : g_tail
            assign nxt = head_in;
        end else begin : g_body
            assign nxt = w_rec[g+1];
        end
        sp_nh_cell u_cell (
            .i_clk   (i_clk),
            .i_init  (compute_acc),
            .i_seed  ((i_row_node == NW'(g)) && ({1'b0, i_row_node} < n_eff)),
            .i_shift (shift),
            .i_next  (nxt),
            .o_rec   (w_rec[g])
        );
    end

    sp_nh_relax u_relax (
        .i_rec        (w_rec[0]),
        .i_wt         (r_wt),
        .i_ctl        (r_ctl),
        .i_node       (r_step),
        .i_node_count (r_n),
        .o_rec        (head_upd),
        .o_cand       (head_cand)
    );

    assign head_in = (r_state == ST_SEARCH) ? head_upd : w_rec[0];

    // Running minimum over the pass; strict compare keeps the lowest index on ties.
    always_comb begin
        n_found     = r_found;
        n_best_dist = r_best_dist;
        n_best_node = r_best_node;
        n_best_hop  = r_best_hop;
        if (head_cand && (!r_found || head_upd.cost < r_best_dist)) begin
            n_found     = 1'b1;
            n_best_dist = head_upd.cost;
            n_best_node = r_step;
            n_best_hop  = head_upd.hop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_step        <= '0;
            r_found       <= 1'b0;
            r_ctl.u_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (compute_acc) begin
                        r_state       <= ST_PREF;
                        r_step        <= '0;
                        r_found       <= 1'b0;
                        r_ctl.u_valid <= 1'b0;
                    end
                end
                ST_PREF: begin
                    r_state <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    r_step <= r_step + NW'(1);
                    if (r_step == NW'(sp_nh_pkg::MAX_NODE_COUNT - 1)) begin
                        r_found <= 1'b0;
                        if (n_found) begin
                            r_ctl.u_valid <= 1'b1;
                            r_state       <= ST_PREF;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end else begin
                        r_found <= n_found;
                    end
                end
                ST_OUT: begin
                    if (out_adv) begin
                        r_step <= r_step + NW'(1);
                        if ({1'b0, r_step} == r_n - CW'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload of the search: settled node and best candidate.
    always_ff @(posedge i_clk) begin
        if (compute_acc) begin
            r_ctl.src <= i_row_node;
            r_n       <= n_eff;
        end
        if (r_state == ST_SEARCH) begin
            r_best_dist <= n_best_dist;
            r_best_node <= n_best_node;
            r_best_hop  <= n_best_hop;
            if (r_step == NW'(sp_nh_pkg::MAX_NODE_COUNT - 1)) begin
                r_ctl.u      <= n_best_node;
                r_ctl.u_dist <= n_best_dist;
                r_ctl.u_hop  <= n_best_hop;
            end
        end
    end

    // Output register: load a route beat when empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && out_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_adv) begin
            r_dest <= r_step;
            r_last <= ({1'b0, r_step} == r_n - CW'(1));
            if (r_step == r_ctl.src) begin
                r_status <= sp_nh_pkg::RS_SELF;
                r_hop    <= '0;
                r_cost   <= '0;
            end else if (!w_rec[0].valid) begin
                r_status <= sp_nh_pkg::RS_UNREACH;
                r_hop    <= '0;
                r_cost   <= '0;
            end else begin
                r_status <= sp_nh_pkg::RS_ROUTED;
                r_hop    <= w_rec[0].hop;
                r_cost   <= w_rec[0].cost;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dest_node    = r_dest;
    assign o_first_hop    = r_hop;
    assign o_path_cost    = r_cost;
    assign o_route_status = r_status;
    assign o_last_entry   = r_last;

    `ASSERT_NOW(a_busy_blocks_in, (r_state != ST_IDLE), !o_in_ready, "input taken while busy")
    `ASSERT_NOW(a_u_in_range, (r_state == ST_SEARCH) && r_ctl.u_valid, ({1'b0, r_ctl.u} < r_n), "settled node out of range")
    `ASSERT_NEXT(a_last_marked, (r_state == ST_OUT) && out_adv && ({1'b0, r_step} == r_n - CW'(1)), o_out_valid && o_last_entry, "final route beat not marked")
endmodule

>>> test/shortest_path_next_hop_table_top_test.sv
module shortest_path_next_hop_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_NODE_COUNT = sp_nh_pkg::MAX_NODE_COUNT;
    localparam logic       OP_LOAD        = sp_nh_pkg::OP_LOAD;
    localparam logic       OP_COMPUTE     = sp_nh_pkg::OP_COMPUTE;
    localparam logic [1:0] RS_ROUTED      = sp_nh_pkg::RS_ROUTED;
    localparam logic [1:0] RS_SELF        = sp_nh_pkg::RS_SELF;
    localparam logic [1:0] RS_UNREACH     = sp_nh_pkg::RS_UNREACH;

    // One route beat as the block should emit it.
    typedef struct {
        logic [4:0]  dest;
        logic [4:0]  hop;
        logic [20:0] cost;
        logic [1:0]  status;
        logic        last;
    } t_route;

    // One row of the directed table. A compute row may pin one destination's
    // route by hand; the rest of that run comes from the predictor.
    typedef struct {
        logic        op;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [15:0] weight;
        logic        absent;
        bit          pinned;
        logic [4:0]  pin_dest;
        logic [4:0]  pin_hop;
        logic [20:0] pin_cost;
        logic [1:0]  pin_status;
    } t_beat_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [4:0]  i_row_node;
    logic [4:0]  i_col_node;
    logic [15:0] i_edge_weight;
    logic        i_edge_absent;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_node_count;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [4:0]  o_dest_node;
    logic [4:0]  o_first_hop;
    logic [20:0] o_path_cost;
    logic [1:0]  o_route_status;
    logic        o_last_entry;

    shortest_path_next_hop_table_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_row_node       (i_row_node),
        .i_col_node       (i_col_node),
        .i_edge_weight    (i_edge_weight),
        .i_edge_absent    (i_edge_absent),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_node_count (i_cfg_node_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_dest_node      (o_dest_node),
        .o_first_hop      (o_first_hop),
        .o_path_cost      (o_path_cost),
        .o_route_status   (o_route_status),
        .o_last_entry     (o_last_entry)
    );

    // Shadow of the adjacency matrix, plus which entries were ever loaded, so
    // that no compute ever reads an entry the hardware leaves undefined.
    logic [15:0] link_weight [MAX_NODE_COUNT*MAX_NODE_COUNT];
    bit          link_absent [MAX_NODE_COUNT*MAX_NODE_COUNT];
    bit          link_loaded [MAX_NODE_COUNT*MAX_NODE_COUNT];
    logic [5:0]  cfg_nodes;

    t_route      pending_routes[$];
    int          err_count;
    int          beats_in;
    int          loads_in;
    int          computes_in;
    int          routes_seen;
    int          burst_left;
    int          stall_phase;

    // Effective node count: zero means one, anything above the ring saturates.
    function automatic int nodes_active();
        int n;
        n = cfg_nodes;
        if (n == 0) n = 1;
        if (n > MAX_NODE_COUNT) n = MAX_NODE_COUNT;
        return n;
    endfunction

    // Dijkstra over the shadow matrix; queue one route per destination.
    function automatic void predict_routes(int src);
        int          n;
        int          u;
        int          cur;
        int          steps;
        bit          reached [MAX_NODE_COUNT];
        bit          settled [MAX_NODE_COUNT];
        bit          has_pred [MAX_NODE_COUNT];
        int          pred [MAX_NODE_COUNT];
        int unsigned best_len [MAX_NODE_COUNT];
        int unsigned cand;
        t_route      r;
        n = nodes_active();
        for (int i = 0; i < MAX_NODE_COUNT; i++) begin
            reached[i] = 0; settled[i] = 0; has_pred[i] = 0; pred[i] = 0; best_len[i] = 0;
        end
        if (src < n) reached[src] = 1;
        for (int pass = 0; pass < n; pass++) begin
            u = -1;
            for (int i = 0; i < n; i++)
                if (!settled[i] && reached[i] && (u < 0 || best_len[i] < best_len[u])) u = i;
            if (u < 0) break;
            settled[u] = 1;
            for (int v = 0; v < n; v++) begin
                if (settled[v] || link_absent[u*MAX_NODE_COUNT+v]) continue;
                cand = best_len[u] + link_weight[u*MAX_NODE_COUNT+v];
                if (!reached[v] || cand < best_len[v]) begin
                    reached[v] = 1; best_len[v] = cand; has_pred[v] = 1; pred[v] = u;
                end
            end
        end
        for (int d = 0; d < n; d++) begin
            r.dest = d[4:0];
            r.hop = '0;
            r.cost = '0;
            r.last = (d == n - 1);
            if (d == src) begin
                r.status = RS_SELF;
            end else if (!reached[d]) begin
                r.status = RS_UNREACH;
            end else begin
                // Walk the parents back to the neighbor of the source.
                cur = d;
                steps = 0;
                while (has_pred[cur] && pred[cur] != src && steps < n) begin
                    cur = pred[cur];
                    steps++;
                end
                if (!has_pred[cur] || pred[cur] != src) begin
                    r.status = RS_UNREACH;
                end else begin
                    r.status = RS_ROUTED;
                    r.hop = cur[4:0];
                    r.cost = best_len[d][20:0];
                end
            end
            pending_routes.push_back(r);
        end
    endfunction

    // A compute is legal when every entry it might read has been loaded.
    function automatic bit compute_safe(int src);
        int n;
        n = nodes_active();
        if (src >= n) return 1;
        for (int i = 0; i < n*MAX_NODE_COUNT; i++)
            if ((i % MAX_NODE_COUNT) < n && !link_loaded[i]) return 0;
        return 1;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("shortest_path_next_hop_table_top_test: errors");
        $finish;
    end

    // Receiver: alternate between always-ready stretches and random stalls.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[6]) i_out_ready <= ($urandom_range(0, 3) != 0);
        else if (stall_phase[5]) i_out_ready <= ($urandom_range(0, 1) != 0);
        else i_out_ready <= 1'b1;
    end

    // Check every route beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_route want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            routes_seen++;
            if (pending_routes.size() == 0) begin
                $error("unexpected route beat dest=%0d", o_dest_node);
                err_count++;
            end else begin
                want = pending_routes.pop_front();
                if (o_dest_node !== want.dest) begin
                    $error("dest_node exp %0d got %0d", want.dest, o_dest_node);
                    err_count++;
                end
                if (o_first_hop !== want.hop) begin
                    $error("first_hop exp %0d got %0d", want.hop, o_first_hop);
                    err_count++;
                end
                if (o_path_cost !== want.cost) begin
                    $error("path_cost exp %0d got %0d", want.cost, o_path_cost);
                    err_count++;
                end
                if (o_route_status !== want.status) begin
                    $error("route_status exp %0d got %0d", want.status, o_route_status);
                    err_count++;
                end
                if (o_last_entry !== want.last) begin
                    $error("last_entry exp %0d got %0d", want.last, o_last_entry);
                    err_count++;
                end
            end
        end
    end

    // Drive one input beat, hold it until accepted, then update the shadow
    // state. Bursts of random length end in random gaps.
    task automatic send_beat(input logic op, input logic [4:0] row, input logic [4:0] col,
                             input logic [15:0] weight, input logic absent);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_operation = op;
        i_row_node = row;
        i_col_node = col;
        i_edge_weight = weight;
        i_edge_absent = absent;
        do @(posedge i_clk); while (!o_in_ready);
        beats_in++;
        if (op == OP_LOAD) begin
            loads_in++;
            link_weight[row*MAX_NODE_COUNT+col] = weight;
            link_absent[row*MAX_NODE_COUNT+col] = absent;
            link_loaded[row*MAX_NODE_COUNT+col] = 1;
        end else begin
            computes_in++;
            predict_routes(row);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Hold off until every route is out and the block has settled, then
    // write the node count.
    task automatic set_node_count(input logic [5:0] value);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_node_count = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_nodes = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 3));
            4, 5:    return 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    t_beat_row directed [] = '{
        // Three-node graph: 0->1 heavy, 0->2 light, 2->1 free.
        '{OP_LOAD,    5'd0,  5'd0, 16'h0000, 1'b0, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        '{OP_LOAD,    5'd0,  5'd1, 16'hFFFF, 1'b0, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        '{OP_LOAD,    5'd0,  5'd2, 16'h0001, 1'b0, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        '{OP_LOAD,    5'd1,  5'd0, 16'hFFFF, 1'b1, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        '{OP_LOAD,    5'd1,  5'd1, 16'h0000, 1'b0, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        '{OP_LOAD,    5'd1,  5'd2, 16'h0000, 1'b1, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        '{OP_LOAD,    5'd2,  5'd0, 16'h1234, 1'b1, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        '{OP_LOAD,    5'd2,  5'd1, 16'h0000, 1'b0, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        '{OP_LOAD,    5'd2,  5'd2, 16'hFFFF, 1'b1, 0, 5'd0, 5'd0, 21'd0, RS_ROUTED},
        // Node 1 is cheaper through node 2 than over the direct link.
        '{OP_COMPUTE, 5'd0,  5'd31, 16'hFFFF, 1'b1, 1, 5'd1, 5'd2, 21'd1, RS_ROUTED},
        '{OP_COMPUTE, 5'd1,  5'd0, 16'h0000, 1'b0, 1, 5'd0, 5'd0, 21'd0, RS_UNREACH},
        '{OP_COMPUTE, 5'd2,  5'd0, 16'h0000, 1'b0, 1, 5'd2, 5'd0, 21'd0, RS_SELF},
        // Source outside the nodes in use: nothing is reachable.
        '{OP_COMPUTE, 5'd31, 5'd0, 16'h0000, 1'b0, 1, 5'd0, 5'd0, 21'd0, RS_UNREACH}
    };

    initial begin
        int n;
        int src;
        int base;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = OP_LOAD;
        i_row_node = '0;
        i_col_node = '0;
        i_edge_weight = '0;
        i_edge_absent = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_node_count = '0;
        i_out_ready = 1'b1;
        stall_phase = 0;
        cfg_nodes = 6'd32;
        err_count = 0;
        beats_in = 0;
        loads_in = 0;
        computes_in = 0;
        routes_seen = 0;
        burst_left = 0;
        for (int i = 0; i < MAX_NODE_COUNT*MAX_NODE_COUNT; i++) begin
            link_weight[i] = '0; link_absent[i] = 0; link_loaded[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full ring at reset size: row 0 reaches node 5 at top weight and
        // node 31 for free; rows 1, 2, 5 and 31 lead nowhere.
        for (int c = 0; c < MAX_NODE_COUNT; c++) begin
            send_beat(OP_LOAD, 5'd0, c[4:0], (c == 5) ? 16'hFFFF : 16'h0000,
                      !(c == 5 || c == 31));
            send_beat(OP_LOAD, 5'd1, c[4:0], pick_weight(), 1'b1);
            send_beat(OP_LOAD, 5'd2, c[4:0], pick_weight(), 1'b1);
            send_beat(OP_LOAD, 5'd5, c[4:0], pick_weight(), 1'b1);
            send_beat(OP_LOAD, 5'd31, c[4:0], pick_weight(), 1'b1);
        end
        send_beat(OP_COMPUTE, 5'd0, 5'd0, 16'h0000, 1'b0);
        send_beat(OP_COMPUTE, 5'd31, 5'd31, 16'hFFFF, 1'b1);

        // Walk the directed table at three nodes.
        set_node_count(6'd3);
        foreach (directed[k]) begin
            send_beat(directed[k].op, directed[k].row, directed[k].col,
                      directed[k].weight, directed[k].absent);
            if (directed[k].pinned) begin
                base = pending_routes.size() - nodes_active();
                pending_routes[base + directed[k].pin_dest].hop = directed[k].pin_hop;
                pending_routes[base + directed[k].pin_dest].cost = directed[k].pin_cost;
                pending_routes[base + directed[k].pin_dest].status = directed[k].pin_status;
            end
        end

        // Node count zero acts as one; an oversized count saturates.
        set_node_count(6'd0);
        send_beat(OP_COMPUTE, 5'd0, 5'd0, 16'h0000, 1'b0);
        send_beat(OP_COMPUTE, 5'd1, 5'd0, 16'h0000, 1'b0);
        set_node_count(6'd63);
        send_beat(OP_COMPUTE, 5'd0, 5'd0, 16'h0000, 1'b0);
        set_node_count(6'd33);
        send_beat(OP_COMPUTE, 5'd31, 5'd0, 16'h0000, 1'b0);

        // Random topologies: mostly small graphs fully loaded, then a few
        // computes mixed with stray loads anywhere in the matrix.
        while (beats_in < 350) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            set_node_count(n[5:0]);
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    send_beat(OP_LOAD, r[4:0], c[4:0], pick_weight(),
                              ($urandom_range(0, 9) < 4));
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 3) == 0)
                    send_beat(OP_LOAD, 5'($urandom), 5'($urandom), pick_weight(),
                              1'($urandom));
                src = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, n - 1);
                if (compute_safe(src))
                    send_beat(OP_COMPUTE, src[4:0], 5'($urandom), 16'($urandom),
                              1'($urandom));
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d beats: %0d matrix loads, %0d route computations,",
                 beats_in, loads_in, computes_in);
        $display("%0d route beats checked over node counts from 0 through 63.", routes_seen);
        if (err_count == 0) begin
            $display("shortest_path_next_hop_table_top_test: clean");
        end else begin
            $display("shortest_path_next_hop_table_top_test: errors");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/sp_nh_pkg.sv
rtl/core/sp_nh_cell.sv
rtl/core/sp_nh_relax.sv
rtl/core/shortest_path_next_hop_table_top.sv
test/shortest_path_next_hop_table_top_test.sv
